// ===== rtl/core/hsu_pkg.sv =====
// Shared types, codes and reset constants of the two-axis homing sequencer.
package hsu_pkg;

  // Field widths
  localparam int unsigned DebounceW = 8;
  localparam int unsigned SettleW   = 12;
  localparam int unsigned StepsW    = 23;
  localparam int unsigned TargetW   = 24;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 23;
  localparam int unsigned InDataW   = 8;
  localparam int unsigned OutDataW  = 40;

  // Configuration reset values
  localparam logic                AzDirCwRst   = 1'b0;
  localparam logic                ElDirUpRst   = 1'b0;
  localparam logic                ElGangedRst  = 1'b0;
  localparam logic                AzPresentRst = 1'b1;
  localparam logic                ElPresentRst = 1'b1;
  localparam logic [DebounceW-1:0] DebounceRst = 8'd5;
  localparam logic [SettleW-1:0]  SettleRst    = 12'd800;
  localparam logic [StepsW-1:0]   MaxStepsRst  = 23'd100000;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_AZ_DIR_CW  = 3'd0,
    CFG_EL_DIR_UP  = 3'd1,
    CFG_EL_GANGED  = 3'd2,
    CFG_AZ_PRESENT = 3'd3,
    CFG_EL_PRESENT = 3'd4,
    CFG_DEBOUNCE   = 3'd5,
    CFG_SETTLE     = 3'd6,
    CFG_MAX_STEPS  = 3'd7
  } cfg_idx_e;

  // Input item kinds
  typedef enum logic {
    KIND_TICK  = 1'b0,
    KIND_START = 1'b1
  } kind_e;

  // Sequencer stages
  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_AZ_PRE    = 3'd1,
    ST_AZ_SEEK   = 3'd2,
    ST_AZ_SETTLE = 3'd3,
    ST_EL_SEEK   = 3'd4,
    ST_DONE      = 3'd5
  } stage_e;

  // Azimuth motor commands
  typedef enum logic [2:0] {
    AZ_NONE     = 3'd0,
    AZ_SEEK     = 3'd1,
    AZ_MOVE_180 = 3'd2,
    AZ_STOP     = 3'd3,
    AZ_ZERO     = 3'd4
  } az_cmd_e;

  // Elevation motor commands
  typedef enum logic [1:0] {
    EL_NONE = 2'd0,
    EL_SEEK = 2'd1,
    EL_STOP = 2'd2,
    EL_ZERO = 2'd3
  } el_cmd_e;

  // Configuration registers as seen by the sequencer
  typedef struct packed {
    logic                 az_dir_cw;
    logic                 el_dir_up;
    logic                 el_ganged;
    logic                 az_present;
    logic                 el_present;
    logic [DebounceW-1:0] debounce_ms;
    logic [SettleW-1:0]   settle_ms;
    logic [StepsW-1:0]    max_steps;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic signed [TargetW-1:0] seek_target;
    logic                      el_second_follows;
    el_cmd_e                   el_cmd;
    az_cmd_e                   az_cmd;
    logic                      el_limit;
    logic                      az_limit;
    logic                      el_homed;
    logic                      az_homed;
    stage_e                    stage;
  } res_t;

  // Signed seek target of the given direction, magnitude max_steps.
  function automatic logic signed [TargetW-1:0] seek_value(logic positive,
                                                           logic [StepsW-1:0] mag);
    logic [TargetW-1:0] ext;
    ext = {1'b0, mag};
    return positive ? $signed(ext) : $signed(-ext);
  endfunction

endpackage

// ===== rtl/core/hsu_debounce.sv =====
// Debouncer for one active-low limit switch, advanced once per tick item.
module hsu_debounce (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          tick_i,
  input  logic                          pin_i,
  input  logic [hsu_pkg::DebounceW-1:0] debounce_ms_i,
  output logic                          limit_o
);
  import hsu_pkg::*;

  logic                 lim_q, lim_d;
  logic [DebounceW-1:0] since_q, since_d;
  logic [DebounceW-1:0] since_inc;
  logic                 raw;

  // Saturating tick count; a change is taken once enough ticks have passed.
  always_comb begin
    raw       = ~pin_i;
    since_inc = (since_q == '1) ? since_q : since_q + 1'b1;
    lim_d     = lim_q;
    since_d   = since_inc;
    if ((raw != lim_q) && (since_inc >= debounce_ms_i)) begin
      lim_d   = raw;
      since_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q   <= 1'b0;
      since_q <= '0;
    end else if (tick_i) begin
      lim_q   <= lim_d;
      since_q <= since_d;
    end
  end

  // The item in flight sees the updated limit state.
  assign limit_o = tick_i ? lim_d : lim_q;

endmodule

// ===== rtl/core/hsu_seq.sv =====
// Homing stage machine: stage, homed flags, settle timer and motor commands.
module hsu_seq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          kind_i,
  input  logic          az_in_range_i,
  input  logic          az_running_i,
  input  logic          az_limit_i,
  input  logic          el_limit_i,
  input  hsu_pkg::cfg_t cfg_i,
  output hsu_pkg::res_t res_o
);
  import hsu_pkg::*;

  stage_e               stage_q, stage_d;
  logic                 az_homed_q, az_homed_d;
  logic                 el_homed_q, el_homed_d;
  logic                 el_stop_q, el_stop_d;
  logic [SettleW-1:0]   settle_q, settle_d;
  logic [SettleW-1:0]   settle_inc;
  logic                 settle_done;
  az_cmd_e              az_cmd;
  el_cmd_e              el_cmd;
  logic signed [TargetW-1:0] target;

  // Next state and commands for the item at hand.
  always_comb begin
    settle_inc  = (settle_q == '1) ? settle_q : settle_q + 1'b1;
    settle_done = (settle_inc >= cfg_i.settle_ms);
    stage_d     = stage_q;
    az_homed_d  = az_homed_q;
    el_homed_d  = el_homed_q;
    el_stop_d   = el_stop_q;
    settle_d    = settle_q;
    az_cmd      = AZ_NONE;
    el_cmd      = EL_NONE;
    target      = '0;
    if (kind_i == KIND_START) begin
      if (cfg_i.az_present) begin
        stage_d    = ST_AZ_PRE;
        az_homed_d = 1'b0;
        settle_d   = '0;
        el_stop_d  = 1'b0;
      end
    end else begin
      case (stage_q)
        ST_AZ_PRE: begin
          if (az_in_range_i) begin
            az_cmd  = AZ_SEEK;
            target  = seek_value(cfg_i.az_dir_cw, cfg_i.max_steps);
            stage_d = ST_AZ_SEEK;
          end else if (!az_running_i) begin
            az_cmd = AZ_MOVE_180;
          end
        end
        ST_AZ_SEEK: begin
          if (az_limit_i) begin
            az_cmd   = AZ_STOP;
            stage_d  = ST_AZ_SETTLE;
            settle_d = '0;
          end
        end
        ST_AZ_SETTLE: begin
          settle_d = settle_inc;
          if (settle_done) begin
            az_cmd     = AZ_ZERO;
            az_homed_d = 1'b1;
            settle_d   = '0;
            el_stop_d  = 1'b0;
            if (cfg_i.el_present) begin
              stage_d    = ST_EL_SEEK;
              el_homed_d = 1'b0;
              el_cmd     = EL_SEEK;
              target     = seek_value(cfg_i.el_dir_up, cfg_i.max_steps);
            end else begin
              stage_d = ST_DONE;
            end
          end
        end
        ST_EL_SEEK: begin
          // A settle cut short by the limit releasing holds its count.
          if (el_limit_i) begin
            if (!el_stop_q) begin
              el_cmd    = EL_STOP;
              el_stop_d = 1'b1;
              settle_d  = '0;
            end else begin
              settle_d = settle_inc;
              if (settle_done) begin
                el_cmd     = EL_ZERO;
                el_homed_d = 1'b1;
                stage_d    = ST_DONE;
                el_stop_d  = 1'b0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q    <= ST_IDLE;
      az_homed_q <= 1'b0;
      el_homed_q <= 1'b0;
      el_stop_q  <= 1'b0;
      settle_q   <= '0;
    end else if (en_i) begin
      stage_q    <= stage_d;
      az_homed_q <= az_homed_d;
      el_homed_q <= el_homed_d;
      el_stop_q  <= el_stop_d;
      settle_q   <= settle_d;
    end
  end

  // Result item built from the updated state.
  always_comb begin
    res_o.stage             = stage_d;
    res_o.az_homed          = az_homed_d;
    res_o.el_homed          = el_homed_d;
    res_o.az_limit          = az_limit_i;
    res_o.el_limit          = el_limit_i;
    res_o.az_cmd            = az_cmd;
    res_o.el_cmd            = el_cmd;
    res_o.el_second_follows = cfg_i.el_ganged && (el_cmd != EL_NONE);
    res_o.seek_target       = target;
  end

  // Elevation and completion stages only follow a finished azimuth home.
  a_done_az_homed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_q == ST_DONE || stage_q == ST_EL_SEEK) |-> az_homed_q)
    else $error("stage past azimuth settle without azimuth homed");

  // The elevation stop mark lives only inside the elevation seek stage.
  a_el_stop_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    el_stop_q |-> (stage_q == ST_EL_SEEK))
    else $error("elevation stop mark outside elevation seek");

  // An accepted start with azimuth present restarts at the prehome stage.
  a_start_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && kind_i == KIND_START && cfg_i.az_present)
      |=> (stage_q == ST_AZ_PRE && !az_homed_q && settle_q == '0))
    else $error("start item did not restart the sequence");

endmodule

// ===== rtl/core/two_axis_homing_sequencer_unit.sv =====
// Top level of the two-axis homing sequencer: ports, registers and item flow.
//
// Each input item (a 1 ms tick or a start command) yields exactly one result
// item. An item is held in an input register, passes through the debouncers
// and the stage logic, and lands in an output register, so the block takes
// one item per clock while the sink takes every result. A result item is
// presented from the output register once its input item has left the input
// register. While a result waits for the sink, one more item can enter the
// input register; after that the input stalls until the waiting result is
// taken. Configuration writes are always ready and should only be issued
// while no item is in flight.
module two_axis_homing_sequencer_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Input items
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // tdata: az_pin, el_pin, az_in_range, az_running, zero fill
  input  logic [hsu_pkg::InDataW-1:0]  s_axis_tdata,
  // tuser: kind
  input  logic                         s_axis_tuser,
  // Result items
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // tdata: stage, az_homed, el_homed, az_limit, el_limit, az_cmd, el_cmd,
  //        el_second_follows, seek_target, zero fill
  output logic [hsu_pkg::OutDataW-1:0] m_axis_tdata,
  // Configuration writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [hsu_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hsu_pkg::CfgDataW-1:0] cfg_data_i
);
  import hsu_pkg::*;

  cfg_t               cfg_q;
  logic               in_vld_q;
  logic               kind_q, az_pin_q, el_pin_q, in_range_q, running_q;
  logic               out_vld_q;
  res_t               out_q;
  res_t               res;
  logic               adv;
  logic               tick;
  logic               az_lim, el_lim;

  // Configuration register file.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.az_dir_cw   <= AzDirCwRst;
      cfg_q.el_dir_up   <= ElDirUpRst;
      cfg_q.el_ganged   <= ElGangedRst;
      cfg_q.az_present  <= AzPresentRst;
      cfg_q.el_present  <= ElPresentRst;
      cfg_q.debounce_ms <= DebounceRst;
      cfg_q.settle_ms   <= SettleRst;
      cfg_q.max_steps   <= MaxStepsRst;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_AZ_DIR_CW:  cfg_q.az_dir_cw   <= cfg_data_i[0];
        CFG_EL_DIR_UP:  cfg_q.el_dir_up   <= cfg_data_i[0];
        CFG_EL_GANGED:  cfg_q.el_ganged   <= cfg_data_i[0];
        CFG_AZ_PRESENT: cfg_q.az_present  <= cfg_data_i[0];
        CFG_EL_PRESENT: cfg_q.el_present  <= cfg_data_i[0];
        CFG_DEBOUNCE:   cfg_q.debounce_ms <= cfg_data_i[DebounceW-1:0];
        CFG_SETTLE:     cfg_q.settle_ms   <= cfg_data_i[SettleW-1:0];
        CFG_MAX_STEPS:  cfg_q.max_steps   <= cfg_data_i[StepsW-1:0];
        default: ;
      endcase
    end
  end

  // Item flow: the held item advances when the output register is free.
  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;
  assign tick          = adv && (kind_q == KIND_TICK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  // Input payload register.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      kind_q     <= s_axis_tuser;
      az_pin_q   <= s_axis_tdata[0];
      el_pin_q   <= s_axis_tdata[1];
      in_range_q <= s_axis_tdata[2];
      running_q  <= s_axis_tdata[3];
    end
  end

  // Limit switch debouncers.
  hsu_debounce u_az_deb (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tick_i        (tick),
    .pin_i         (az_pin_q),
    .debounce_ms_i (cfg_q.debounce_ms),
    .limit_o       (az_lim)
  );

  hsu_debounce u_el_deb (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tick_i        (tick),
    .pin_i         (el_pin_q),
    .debounce_ms_i (cfg_q.debounce_ms),
    .limit_o       (el_lim)
  );

  // Stage machine.
  hsu_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (adv),
    .kind_i        (kind_q),
    .az_in_range_i (in_range_q),
    .az_running_i  (running_q),
    .az_limit_i    (az_lim),
    .el_limit_i    (el_lim),
    .cfg_i         (cfg_q),
    .res_o         (res)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || m_axis_tready) begin
      out_vld_q <= adv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OutDataW - $bits(res_t)){1'b0}}, out_q};

endmodule

// ===== dv/two_axis_homing_sequencer_unit_test.sv =====
// Self-checking testbench of the two-axis homing sequencer: predicts every result item.
`timescale 1ns / 100ps

module two_axis_homing_sequencer_unit_test;
  import hsu_pkg::*;

  localparam int RandomItems    = 440;
  localparam int SteadyItems    = 64;
  localparam int SinkHoldCycles = 64;
  localparam int IdlePercent    = 6;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // tdata: az_pin, el_pin, az_in_range, az_running, zero fill
  logic [InDataW-1:0]  s_axis_tdata;
  // tuser: kind
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // tdata: stage, az_homed, el_homed, az_limit, el_limit, az_cmd, el_cmd,
  //        el_second_follows, seek_target, zero fill
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  two_axis_homing_sequencer_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 100 MHz clock.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Predicted sequencer state and the register values it runs with.
  cfg_t         cfg_now;
  stage_e       stage_now;
  logic         az_homed_now, el_homed_now, az_lim_now, el_lim_now, el_stopped;
  logic [7:0]   az_since, el_since;
  logic [11:0]  settle_cnt;

  // Expected status items, oldest first.
  res_t status_q[$];

  int   items_sent, starts_sent, results_seen, mismatches, runs_done, settle_holds;
  bit   steady_flow;
  bit   hold_sink;
  res_t seen_status, due_status;

  // Debounce one active-low pin; returns the new {limit, ticks since change}.
  function automatic logic [8:0] debounce_pin(logic lim, logic [7:0] since, logic pin);
    logic raw;
    raw = ~pin;
    if (since != 8'd255) since++;
    if (raw != lim && since >= cfg_now.debounce_ms) begin
      lim   = raw;
      since = '0;
    end
    return {lim, since};
  endfunction

  // Two's complement seek target of max_steps in the given direction.
  function automatic logic [TargetW-1:0] seek_target_for(logic positive);
    logic [TargetW-1:0] mag;
    mag = {1'b0, cfg_now.max_steps};
    return positive ? mag : TargetW'(0) - mag;
  endfunction

  // One settle tick: the count saturates and is compared after the increment.
  function automatic bit settle_elapsed();
    if (settle_cnt != 12'd4095) settle_cnt++;
    return settle_cnt >= cfg_now.settle_ms;
  endfunction

  // Advance the predicted sequencer by one input item and return its status item.
  function automatic res_t advance_sequencer(kind_e kind, logic [3:0] pins);
    res_t               r;
    az_cmd_e            az_cmd;
    el_cmd_e            el_cmd;
    logic [TargetW-1:0] target;
    az_cmd = AZ_NONE;
    el_cmd = EL_NONE;
    target = '0;
    if (kind == KIND_START) begin
      // A start command restarts the sequence if azimuth is present, without sampling the pins.
      if (cfg_now.az_present) begin
        stage_now    = ST_AZ_PRE;
        az_homed_now = 1'b0;
        settle_cnt   = '0;
        el_stopped   = 1'b0;
      end
    end else begin
      {az_lim_now, az_since} = debounce_pin(az_lim_now, az_since, pins[0]);
      {el_lim_now, el_since} = debounce_pin(el_lim_now, el_since, pins[1]);
      case (stage_now)
        ST_AZ_PRE: begin
          if (pins[2]) begin
            az_cmd    = AZ_SEEK;
            target    = seek_target_for(cfg_now.az_dir_cw);
            stage_now = ST_AZ_SEEK;
          end else if (!pins[3]) begin
            az_cmd = AZ_MOVE_180;
          end
        end
        ST_AZ_SEEK: begin
          if (az_lim_now) begin
            az_cmd     = AZ_STOP;
            stage_now  = ST_AZ_SETTLE;
            settle_cnt = '0;
          end
        end
        ST_AZ_SETTLE: begin
          if (settle_elapsed()) begin
            az_cmd       = AZ_ZERO;
            az_homed_now = 1'b1;
            settle_cnt   = '0;
            el_stopped   = 1'b0;
            if (cfg_now.el_present) begin
              stage_now    = ST_EL_SEEK;
              el_homed_now = 1'b0;
              el_cmd       = EL_SEEK;
              target       = seek_target_for(cfg_now.el_dir_up);
            end else begin
              stage_now = ST_DONE;
              runs_done++;
            end
          end
        end
        ST_EL_SEEK: begin
          // The elevation settle only counts while the limit is active.
          if (el_lim_now) begin
            if (!el_stopped) begin
              el_cmd     = EL_STOP;
              el_stopped = 1'b1;
              settle_cnt = '0;
            end else if (settle_elapsed()) begin
              el_cmd       = EL_ZERO;
              el_homed_now = 1'b1;
              stage_now    = ST_DONE;
              el_stopped   = 1'b0;
              runs_done++;
            end
          end else if (el_stopped) begin
            settle_holds++;
          end
        end
        default: ;
      endcase
    end
    r.stage             = stage_now;
    r.az_homed          = az_homed_now;
    r.el_homed          = el_homed_now;
    r.az_limit          = az_lim_now;
    r.el_limit          = el_lim_now;
    r.az_cmd            = az_cmd;
    r.el_cmd            = el_cmd;
    r.el_second_follows = cfg_now.el_ganged && (el_cmd != EL_NONE);
    r.seek_target       = target;
    return r;
  endfunction

  function automatic logic [3:0] tick_pins(logic az_pin, logic el_pin, logic in_range,
                                           logic running);
    return {running, in_range, el_pin, az_pin};
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("result %0d: %s is %0d, expected %0d", results_seen, what, got, want);
    mismatches++;
  endtask

  // Compare each accepted status item with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      seen_status = res_t'(m_axis_tdata[36:0]);
      if (status_q.size() == 0) begin
        report_mismatch("result with nothing pending, stage", longint'(seen_status.stage),
                        longint'(0));
      end else begin
        due_status = status_q.pop_front();
        if (seen_status.stage !== due_status.stage)
          report_mismatch("stage", longint'(seen_status.stage), longint'(due_status.stage));
        if (seen_status.az_homed !== due_status.az_homed)
          report_mismatch("az_homed", longint'(seen_status.az_homed),
                          longint'(due_status.az_homed));
        if (seen_status.el_homed !== due_status.el_homed)
          report_mismatch("el_homed", longint'(seen_status.el_homed),
                          longint'(due_status.el_homed));
        if (seen_status.az_limit !== due_status.az_limit)
          report_mismatch("az_limit", longint'(seen_status.az_limit),
                          longint'(due_status.az_limit));
        if (seen_status.el_limit !== due_status.el_limit)
          report_mismatch("el_limit", longint'(seen_status.el_limit),
                          longint'(due_status.el_limit));
        if (seen_status.az_cmd !== due_status.az_cmd)
          report_mismatch("az_cmd", longint'(seen_status.az_cmd), longint'(due_status.az_cmd));
        if (seen_status.el_cmd !== due_status.el_cmd)
          report_mismatch("el_cmd", longint'(seen_status.el_cmd), longint'(due_status.el_cmd));
        if (seen_status.el_second_follows !== due_status.el_second_follows)
          report_mismatch("el_second_follows", longint'(seen_status.el_second_follows),
                          longint'(due_status.el_second_follows));
        if (seen_status.seek_target !== due_status.seek_target)
          report_mismatch("seek_target", longint'(seen_status.seek_target),
                          longint'(due_status.seek_target));
        if (m_axis_tdata[39:37] !== 3'b000)
          report_mismatch("zero fill", longint'(m_axis_tdata[39:37]), longint'(0));
      end
    end
  end

  // Result sink: random stalls, plus one long hold-off on request.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_sink) begin
        m_axis_tready <= 1'b0;
        for (int i = 0; i < SinkHoldCycles; i++) @(negedge clk_i);
        hold_sink = 1'b0;
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= steady_flow || ($urandom_range(99) >= IdlePercent);
      end
    end
  end

  // Offer one item from a falling edge; valid stays high for a following item.
  task automatic send_item(kind_e kind, logic [3:0] pins);
    if (!steady_flow && $urandom_range(99) < IdlePercent) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {4'b0000, pins};
    forever begin
      @(posedge clk_i);
      if (s_axis_tready) break;
    end
    status_q.push_back(advance_sequencer(kind, pins));
    items_sent++;
    if (kind == KIND_START) starts_sent++;
    @(negedge clk_i);
  endtask

  // Stop offering items and let every pending result come out.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (status_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_setting(cfg_idx_e idx, logic [CfgDataW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    case (idx)
      CFG_AZ_DIR_CW:  cfg_now.az_dir_cw   = value[0];
      CFG_EL_DIR_UP:  cfg_now.el_dir_up   = value[0];
      CFG_EL_GANGED:  cfg_now.el_ganged   = value[0];
      CFG_AZ_PRESENT: cfg_now.az_present  = value[0];
      CFG_EL_PRESENT: cfg_now.el_present  = value[0];
      CFG_DEBOUNCE:   cfg_now.debounce_ms = value[DebounceW-1:0];
      CFG_SETTLE:     cfg_now.settle_ms   = value[SettleW-1:0];
      CFG_MAX_STEPS:  cfg_now.max_steps   = value[StepsW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Write every register once the block has gone quiet.
  task automatic apply_settings(cfg_t c);
    wait_idle();
    write_setting(CFG_AZ_DIR_CW, CfgDataW'(c.az_dir_cw));
    write_setting(CFG_EL_DIR_UP, CfgDataW'(c.el_dir_up));
    write_setting(CFG_EL_GANGED, CfgDataW'(c.el_ganged));
    write_setting(CFG_AZ_PRESENT, CfgDataW'(c.az_present));
    write_setting(CFG_EL_PRESENT, CfgDataW'(c.el_present));
    write_setting(CFG_DEBOUNCE, CfgDataW'(c.debounce_ms));
    write_setting(CFG_SETTLE, CfgDataW'(c.settle_ms));
    write_setting(CFG_MAX_STEPS, CfgDataW'(c.max_steps));
    cfg_valid_i <= 1'b0;
  endtask

  // Drive one homing run with pins steered by the predicted stage, so that the
  // sequence gets through every stage; a share of items is pure noise.
  task automatic run_homing_sequence(input int cap, input int noise_pct, input bit with_start,
                                     output int sent);
    logic [3:0] pins;
    kind_e      kind;
    int         quiet_ticks;
    sent        = 0;
    quiet_ticks = 0;
    if (with_start) begin
      send_item(KIND_START, 4'($urandom));
      sent++;
    end
    while (sent < cap && quiet_ticks < 4) begin
      kind = KIND_TICK;
      pins = 4'($urandom);
      if ($urandom_range(99) < noise_pct) begin
        if ($urandom_range(1) == 1) kind = KIND_START;
      end else begin
        case (stage_now)
          ST_AZ_PRE:                pins[2] = ($urandom_range(99) < 35);
          ST_AZ_SEEK, ST_AZ_SETTLE: pins[0] = ($urandom_range(99) < 10);
          ST_EL_SEEK:               pins[1] = ($urandom_range(99) < 12);
          default: ;
        endcase
      end
      send_item(kind, pins);
      sent++;
      if (stage_now == ST_DONE || stage_now == ST_IDLE) quiet_ticks++;
    end
  endtask

  function automatic int run_cap(cfg_t c);
    return 200 + 4 * int'(c.settle_ms) + 12 * int'(c.debounce_ms);
  endfunction

  // Field extremes, every command and the named corner cases.
  task automatic test_directed_cases();
    cfg_t c;
    // Reset values: slow debounce and a negative azimuth seek of 100000 steps.
    send_item(KIND_TICK, tick_pins(1'b0, 1'b0, 1'b1, 1'b0));
    send_item(KIND_START, tick_pins(1'b1, 1'b1, 1'b0, 1'b0));
    send_item(KIND_TICK, tick_pins(1'b1, 1'b1, 1'b1, 1'b0));
    // Instant debounce, short settle, widest positive seek, ganged elevation.
    c = cfg_now;
    c.az_dir_cw   = 1'b1;
    c.el_dir_up   = 1'b0;
    c.el_ganged   = 1'b1;
    c.debounce_ms = '0;
    c.settle_ms   = 12'd2;
    c.max_steps   = '1;
    apply_settings(c);
    send_item(KIND_START, tick_pins(1'b0, 1'b0, 1'b0, 1'b0));
    send_item(KIND_TICK, tick_pins(1'b1, 1'b1, 1'b0, 1'b1));
    send_item(KIND_TICK, tick_pins(1'b1, 1'b1, 1'b0, 1'b0));
    send_item(KIND_TICK, tick_pins(1'b1, 1'b1, 1'b1, 1'b0));
    send_item(KIND_TICK, tick_pins(1'b0, 1'b1, 1'b1, 1'b1));
    send_item(KIND_TICK, tick_pins(1'b0, 1'b1, 1'b1, 1'b1));
    send_item(KIND_TICK, tick_pins(1'b1, 1'b1, 1'b1, 1'b1));
    // Elevation stop, then a limit release that holds the settle count.
    send_item(KIND_TICK, tick_pins(1'b1, 1'b0, 1'b0, 1'b0));
    send_item(KIND_TICK, tick_pins(1'b1, 1'b1, 1'b0, 1'b0));
    send_item(KIND_TICK, tick_pins(1'b1, 1'b0, 1'b0, 1'b0));
    send_item(KIND_TICK, tick_pins(1'b1, 1'b0, 1'b0, 1'b0));
    send_item(KIND_TICK, tick_pins(1'b1, 1'b0, 1'b1, 1'b1));
    send_item(KIND_START, tick_pins(1'b1, 1'b1, 1'b1, 1'b1));
    // Without an azimuth motor a start command changes nothing.
    c.az_present = 1'b0;
    apply_settings(c);
    send_item(KIND_START, tick_pins(1'b1, 1'b1, 1'b1, 1'b1));
    send_item(KIND_TICK, tick_pins(1'b1, 1'b1, 1'b0, 1'b0));
    // Zero seek magnitude, no settle time and no elevation motor.
    c.az_present = 1'b1;
    c.el_present = 1'b0;
    c.max_steps  = '0;
    c.settle_ms  = '0;
    c.el_ganged  = 1'b0;
    c.az_dir_cw  = 1'b0;
    apply_settings(c);
    send_item(KIND_START, tick_pins(1'b1, 1'b1, 1'b0, 1'b0));
    send_item(KIND_TICK, tick_pins(1'b1, 1'b1, 1'b1, 1'b0));
    send_item(KIND_TICK, tick_pins(1'b0, 1'b1, 1'b1, 1'b0));
    send_item(KIND_TICK, tick_pins(1'b0, 1'b1, 1'b1, 1'b0));
  endtask

  // Longest debounce and settle with the smallest nonzero seek, both sides never idle.
  task automatic test_extreme_settings();
    cfg_t c;
    int   n;
    c.az_dir_cw   = 1'b0;
    c.el_dir_up   = 1'b1;
    c.el_ganged   = 1'b1;
    c.az_present  = 1'b1;
    c.el_present  = 1'b1;
    c.debounce_ms = '1;
    c.settle_ms   = '1;
    c.max_steps   = 23'd1;
    apply_settings(c);
    steady_flow = 1'b1;
    run_homing_sequence(SteadyItems, 0, 1'b1, n);
    steady_flow = 1'b0;
  endtask

  // The sink holds off long enough for the block to stall its input.
  task automatic test_output_backpressure();
    cfg_t c;
    int   n;
    c             = cfg_now;
    c.debounce_ms = 8'd1;
    c.settle_ms   = 12'd3;
    c.el_present  = 1'b1;
    apply_settings(c);
    hold_sink = 1'b1;
    run_homing_sequence(40, 0, 1'b1, n);
  endtask

  // Homing runs with random settings and random pin content.
  task automatic test_random_homing();
    cfg_t c;
    int   n;
    int   total;
    int   cap;
    total = 0;
    while (total < RandomItems) begin
      c.az_dir_cw   = 1'($urandom);
      c.el_dir_up   = 1'($urandom);
      c.el_ganged   = 1'($urandom);
      c.az_present  = ($urandom_range(99) < 90);
      c.el_present  = ($urandom_range(99) < 80);
      c.debounce_ms = ($urandom_range(99) < 5) ? 8'($urandom) : 8'($urandom_range(6));
      c.settle_ms   = ($urandom_range(99) < 5) ? 12'($urandom_range(300))
                                              : 12'($urandom_range(12));
      c.max_steps   = 23'($urandom);
      if (c.max_steps == '0) c.max_steps = 23'd1;
      apply_settings(c);
      cap = run_cap(c);
      if (cap > RandomItems - total) cap = RandomItems - total;
      run_homing_sequence(cap, 12, ($urandom_range(99) < 90), n);
      total += n;
    end
  endtask

  // Run limit.
  initial begin
    #5_000_000;
    $display("two_axis_homing_sequencer_unit test failed");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    steady_flow   = 1'b0;
    hold_sink     = 1'b0;
    items_sent    = 0;
    starts_sent   = 0;
    results_seen  = 0;
    mismatches    = 0;
    runs_done     = 0;
    settle_holds  = 0;
    cfg_now = '{az_dir_cw: AzDirCwRst, el_dir_up: ElDirUpRst, el_ganged: ElGangedRst,
                az_present: AzPresentRst, el_present: ElPresentRst,
                debounce_ms: DebounceRst, settle_ms: SettleRst,
                max_steps: MaxStepsRst};
    stage_now    = ST_IDLE;
    az_homed_now = 1'b0;
    el_homed_now = 1'b0;
    az_lim_now   = 1'b0;
    el_lim_now   = 1'b0;
    el_stopped   = 1'b0;
    az_since     = '0;
    el_since     = '0;
    settle_cnt   = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed_cases();
    test_extreme_settings();
    test_output_backpressure();
    test_random_homing();

    wait_idle();
    repeat (8) @(negedge clk_i);
    $display("Checked %0d result items for %0d input items, %0d of them start commands.",
             results_seen, items_sent, starts_sent);
    $display("%0d homing runs completed; the elevation settle held on %0d released ticks.",
             runs_done, settle_holds);
    if (mismatches == 0) begin
      $display("two_axis_homing_sequencer_unit test passed");
    end else begin
      $display("two_axis_homing_sequencer_unit test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/hsu_pkg.sv
rtl/core/hsu_debounce.sv
rtl/core/hsu_seq.sv
rtl/core/two_axis_homing_sequencer_unit.sv
dv/two_axis_homing_sequencer_unit_test.sv
